// File: src/ttt_pkg.sv
// Shared types and constants for the template tag tokenizer.
// Holds the token record, the result-slot bundle and the size constants.
// No dependencies.
package ttt_pkg;

  // Field widths of a token record.
  localparam int unsigned POS_W  = 21;
  localparam int unsigned LINE_W = 20;

  // Offsets saturate at the smaller of the document limit and the field maximum.
  localparam longint unsigned MAX_DOC_BYTES = 64'd1048576;
  localparam logic [POS_W-1:0] FIELD_MAX = '1;
  localparam logic [POS_W-1:0] POS_CAP =
      (MAX_DOC_BYTES < 64'(FIELD_MAX)) ? POS_W'(MAX_DOC_BYTES) : FIELD_MAX;
  localparam logic [LINE_W-1:0] LINE_CAP = '1;

  // One input item causes at most this many results.
  localparam int unsigned MAX_RESULTS = 3;

  // Result queue sizing.
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W      = PTR_W + 1;

  // Token kinds as they appear on the output.
  typedef enum logic [3:0] {
    K_TEXT       = 4'd0,
    K_VAR_OPEN   = 4'd1,
    K_VAR_CLOSE  = 4'd2,
    K_STMT_OPEN  = 4'd3,
    K_STMT_CLOSE = 4'd4,
    K_CMT_OPEN   = 4'd5,
    K_CMT_CLOSE  = 4'd6,
    K_IDENT      = 4'd7,
    K_NUMBER     = 4'd8,
    K_STRING     = 4'd9,
    K_ILLEGAL    = 4'd10,
    K_END        = 4'd11
  } kind_e;

  // One token descriptor.
  typedef struct packed {
    kind_e             kind;
    logic [POS_W-1:0]  start;
    logic [POS_W-1:0]  len;
    logic [LINE_W-1:0] line;
    logic              last;
  } token_t;

  // Results of one item, in order, with a valid bit per slot.
  typedef struct packed {
    logic [MAX_RESULTS-1:0] valid;
    token_t [MAX_RESULTS-1:0] slot;
  } push_t;

endpackage

// File: src/ttt_lexer.sv
// Scanner state and per-item decision logic of the template tag tokenizer.
// Produces up to three ordered token records for each accepted item.
// Depends on ttt_pkg.
module ttt_lexer
  import ttt_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] data_byte_i,
  input  logic       end_of_input_i,
  output push_t      push_o
);

  typedef enum logic [2:0] {
    SM_IDLE   = 3'd0,
    SM_TEXT   = 3'd1,
    SM_IDENT  = 3'd2,
    SM_NUMBER = 3'd3,
    SM_STRING = 3'd4,
    SM_HELD   = 3'd5
  } scan_e;

  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_USCORE = 8'h5F;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;

  function automatic logic [POS_W-1:0] sat_inc(input logic [POS_W-1:0] v);
    return (v < POS_CAP) ? v + POS_W'(1) : POS_CAP;
  endfunction

  function automatic logic [POS_W-1:0] sat_diff(input logic [POS_W-1:0] a,
                                                input logic [POS_W-1:0] b);
    return (a > b) ? a - b : '0;
  endfunction

  function automatic token_t mk_tok(input kind_e k, input logic [POS_W-1:0] s,
                                    input logic [POS_W-1:0] l,
                                    input logic [LINE_W-1:0] ln);
    token_t t;
    t.kind  = k;
    t.start = s;
    t.len   = l;
    t.line  = ln;
    t.last  = 1'b0;
    return t;
  endfunction

  // State registers.
  logic              in_tag_q, in_tag_d;
  scan_e             scan_q, scan_d;
  logic [7:0]        pend_byte_q, pend_byte_d;
  logic              pend_valid_q, pend_valid_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [POS_W-1:0]  start_q, start_d;
  logic [LINE_W-1:0] line_q, line_d;
  kind_e             held_kind_q, held_kind_d;
  logic [POS_W-1:0]  held_off_q, held_off_d;

  // Byte classes and derived values.
  logic [7:0]        c, b;
  logic              c_alpha, c_digit, c_ident, c_space, c_quote, c_start;
  logic              b_open;
  kind_e             open_kind;
  logic [POS_W-1:0]  pos_inc, end_pos;
  logic [LINE_W-1:0] line_inc;

  // Decision flags.
  logic              tag_beg, tag_fin, hold;
  kind_e             hold_kind;
  logic              hold_tag;
  push_t             push;

  assign c = pend_byte_q;
  assign b = data_byte_i;

  always_comb begin
    c_alpha = ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    c_digit = (c >= 8'h30) && (c <= 8'h39);
    c_ident = c_alpha || c_digit || (c == CH_USCORE);
    c_start = c_alpha || (c == CH_USCORE);
    c_space = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
    c_quote = (c == CH_QUOTE);
    b_open  = (b == CH_LBRACE) || (b == CH_PCT) || (b == CH_HASH);
    if (b == CH_PCT) begin
      open_kind = K_STMT_OPEN;
    end else if (b == CH_HASH) begin
      open_kind = K_CMT_OPEN;
    end else begin
      open_kind = K_VAR_OPEN;
    end
    pos_inc  = sat_inc(pos_q);
    end_pos  = pend_valid_q ? pos_inc : '0;
    line_inc = ((b == CH_LF) && (line_q < LINE_CAP)) ? line_q + LINE_W'(1) : line_q;
  end

  // Next state and results for the item being accepted.
  always_comb begin
    kind_e k;
    logic  more;
    in_tag_d     = in_tag_q;
    scan_d       = scan_q;
    pend_byte_d  = pend_byte_q;
    pend_valid_d = pend_valid_q;
    pos_d        = pos_q;
    start_d      = start_q;
    line_d       = line_q;
    held_kind_d  = held_kind_q;
    held_off_d   = held_off_q;
    tag_beg      = 1'b0;
    tag_fin      = 1'b0;
    hold         = 1'b0;
    hold_kind    = K_VAR_OPEN;
    hold_tag     = 1'b0;
    push.valid   = '0;
    for (int i = 0; i < MAX_RESULTS; i++) begin
      push.slot[i] = mk_tok(K_TEXT, '0, '0, line_q);
    end
    k    = (scan_q == SM_IDENT) ? K_IDENT : K_NUMBER;
    more = (scan_q == SM_IDENT) ? c_ident : c_digit;

    if (accept_i && end_of_input_i) begin
      // End of document: flush the open token, then the end token.
      if (pend_valid_q) begin
        unique case (scan_q) inside
          SM_HELD: begin
            push.valid[0] = 1'b1;
            push.slot[0]  = mk_tok(held_kind_q, held_off_q, POS_W'(2), line_q);
          end
          SM_IDENT, SM_NUMBER: begin
            push.valid[0] = 1'b1;
            if (more) begin
              push.slot[0] = mk_tok(k, start_q, sat_diff(end_pos, start_q), line_q);
            end else begin
              push.slot[0] = mk_tok(k, start_q, sat_diff(pos_q, start_q), line_q);
              tag_fin      = 1'b1;
            end
          end
          SM_STRING: begin
            push.valid[0] = 1'b1;
            push.slot[0]  = mk_tok(K_STRING, start_q,
                                   sat_diff(c_quote ? pos_q : end_pos, start_q), line_q);
          end
          SM_TEXT: begin
            push.valid[0] = 1'b1;
            push.slot[0]  = mk_tok(K_TEXT, start_q, sat_diff(end_pos, start_q), line_q);
          end
          default: begin
            if (!in_tag_q) begin
              push.valid[0] = 1'b1;
              push.slot[0]  = mk_tok(K_TEXT, pos_q, sat_diff(end_pos, pos_q), line_q);
            end else begin
              tag_fin = 1'b1;
            end
          end
        endcase
      end
      // Last byte seen in tag mode with no lookahead left.
      if (tag_fin && !c_space) begin
        push.valid[1] = 1'b1;
        if (c_start) begin
          push.slot[1] = mk_tok(K_IDENT, pos_q, sat_diff(end_pos, pos_q), line_q);
        end else if (c_digit) begin
          push.slot[1] = mk_tok(K_NUMBER, pos_q, sat_diff(end_pos, pos_q), line_q);
        end else if (c_quote) begin
          push.slot[1] = mk_tok(K_STRING, end_pos, '0, line_q);
        end else begin
          push.slot[1] = mk_tok(K_ILLEGAL, pos_q, POS_W'(1), line_q);
        end
      end
      push.valid[2] = 1'b1;
      push.slot[2]  = mk_tok(K_END, end_pos, '0, line_q);
      // Back to the reset state for the next document.
      in_tag_d     = 1'b0;
      scan_d       = SM_IDLE;
      pend_byte_d  = '0;
      pend_valid_d = 1'b0;
      pos_d        = '0;
      start_d      = '0;
      line_d       = LINE_W'(1);
      held_kind_d  = K_TEXT;
      held_off_d   = '0;
    end else if (accept_i) begin
      // The new byte always becomes the pending byte.
      pos_d        = pend_valid_q ? pos_inc : pos_q;
      pend_byte_d  = b;
      pend_valid_d = 1'b1;
      line_d       = line_inc;
      if (pend_valid_q) begin
        unique case (scan_q) inside
          SM_HELD: begin
            push.valid[0] = 1'b1;
            push.slot[0]  = mk_tok(held_kind_q, held_off_q, POS_W'(2), line_inc);
            scan_d        = SM_IDLE;
          end
          SM_IDENT, SM_NUMBER: begin
            if (!more) begin
              push.valid[0] = 1'b1;
              push.slot[0]  = mk_tok(k, start_q, sat_diff(pos_q, start_q), line_q);
              scan_d        = SM_IDLE;
              tag_beg       = 1'b1;
            end
          end
          SM_STRING: begin
            if (c_quote) begin
              push.valid[0] = 1'b1;
              push.slot[0]  = mk_tok(K_STRING, start_q, sat_diff(pos_q, start_q), line_inc);
              scan_d        = SM_IDLE;
            end
          end
          SM_TEXT: begin
            if ((c == CH_LBRACE) && b_open) begin
              push.valid[0] = 1'b1;
              push.slot[0]  = mk_tok(K_TEXT, start_q, sat_diff(pos_q, start_q), line_q);
              hold          = 1'b1;
              hold_kind     = open_kind;
              hold_tag      = 1'b1;
            end
          end
          default: begin
            if (in_tag_q) begin
              tag_beg = 1'b1;
            end else if ((c == CH_LBRACE) && b_open) begin
              hold      = 1'b1;
              hold_kind = open_kind;
              hold_tag  = 1'b1;
            end else begin
              start_d = pos_q;
              scan_d  = SM_TEXT;
            end
          end
        endcase
      end
      // Tag mode with no token open: classify the pending byte.
      if (tag_beg) begin
        scan_d = SM_IDLE;
        if (c_space) begin
          scan_d = SM_IDLE;
        end else if ((b == CH_RBRACE) && (c == CH_RBRACE)) begin
          hold      = 1'b1;
          hold_kind = K_VAR_CLOSE;
        end else if ((b == CH_RBRACE) && (c == CH_PCT)) begin
          hold      = 1'b1;
          hold_kind = K_STMT_CLOSE;
        end else if ((b == CH_RBRACE) && (c == CH_HASH)) begin
          hold      = 1'b1;
          hold_kind = K_CMT_CLOSE;
        end else if ((c == CH_LBRACE) && b_open) begin
          hold      = 1'b1;
          hold_kind = open_kind;
          hold_tag  = 1'b1;
        end else if (c_start) begin
          start_d = pos_q;
          scan_d  = SM_IDENT;
        end else if (c_digit) begin
          start_d = pos_q;
          scan_d  = SM_NUMBER;
        end else if (c_quote) begin
          start_d = pos_inc;
          scan_d  = SM_STRING;
        end else begin
          push.valid[1] = 1'b1;
          push.slot[1]  = mk_tok(K_ILLEGAL, pos_q, POS_W'(1), line_q);
        end
      end
      // A delimiter is held and reported with the next item.
      if (hold) begin
        held_kind_d = hold_kind;
        held_off_d  = pos_q;
        in_tag_d    = hold_tag;
        scan_d      = SM_HELD;
      end
    end
  end

  // Flag the final result of the item.
  always_comb begin
    logic seen;
    push_o = push;
    seen   = 1'b0;
    for (int i = MAX_RESULTS - 1; i >= 0; i--) begin
      push_o.slot[i].last = push.valid[i] && !seen;
      seen                = seen || push.valid[i];
    end
  end

  // Scanner state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_tag_q     <= 1'b0;
      scan_q       <= SM_IDLE;
      pend_byte_q  <= '0;
      pend_valid_q <= 1'b0;
      pos_q        <= '0;
      start_q      <= '0;
      line_q       <= LINE_W'(1);
      held_kind_q  <= K_TEXT;
      held_off_q   <= '0;
    end else begin
      in_tag_q     <= in_tag_d;
      scan_q       <= scan_d;
      pend_byte_q  <= pend_byte_d;
      pend_valid_q <= pend_valid_d;
      pos_q        <= pos_d;
      start_q      <= start_d;
      line_q       <= line_d;
      held_kind_q  <= held_kind_d;
      held_off_q   <= held_off_d;
    end
  end

`ifndef SYNTH
  // Exactly one result carries the last flag whenever an item causes results.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (|push_o.valid) |-> ($countones({push_o.slot[2].last, push_o.slot[1].last,
                                     push_o.slot[0].last}) == 1))
    else $error("ttt_lexer: last flag not unique");

  // The end token appears exactly for end items.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.valid[2] == (accept_i && end_of_input_i))
    else $error("ttt_lexer: end token mismatch");

  // An end item returns the scanner to its reset state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && end_of_input_i) |=>
      (!pend_valid_q && (scan_q == SM_IDLE) && !in_tag_q && (line_q == LINE_W'(1))))
    else $error("ttt_lexer: state not cleared after end of input");
`endif

endmodule

// File: src/ttt_fifo.sv
// Result queue of the template tag tokenizer.
// Takes up to three ordered token records per cycle and hands out one per cycle while pop_i is high.
// Depends on ttt_pkg.
module ttt_fifo
  import ttt_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  push_t  push_i,
  input  logic   pop_i,
  output logic   room_o,
  output logic   valid_o,
  output token_t head_o
);

  token_t           mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [PTR_W-1:0] wr_idx [MAX_RESULTS];
  logic [1:0]       n_push;

  // Pack the valid slots into consecutive entries.
  always_comb begin
    logic [1:0] offs;
    offs = '0;
    for (int i = 0; i < MAX_RESULTS; i++) begin
      wr_idx[i] = wr_ptr_q + PTR_W'(offs);
      offs      = offs + 2'(push_i.valid[i]);
    end
    n_push = offs;
  end

  assign valid_o  = (count_q != '0);
  assign head_o   = mem_q[rd_ptr_q];
  assign room_o   = (count_q <= CNT_W'(FIFO_DEPTH - MAX_RESULTS));
  assign wr_ptr_d = wr_ptr_q + PTR_W'(n_push);
  assign rd_ptr_d = rd_ptr_q + PTR_W'(pop_i && valid_o);
  assign count_d  = count_q + CNT_W'(n_push) - CNT_W'(pop_i && valid_o);

  // Entry storage.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MAX_RESULTS; i++) begin
      if (push_i.valid[i]) begin
        mem_q[wr_idx[i]] <= push_i.slot[i];
      end
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

`ifndef SYNTH
  // Results are only written while there is room for a whole item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (|push_i.valid) |-> room_o)
    else $error("ttt_fifo: push without room");

  // The fill count stays within the depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(FIFO_DEPTH))
    else $error("ttt_fifo: overflow");

  // The fill count follows pushes and pops.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (count_q == $past(count_q) + CNT_W'($past(n_push))
              - CNT_W'($past(pop_i && valid_o))))
    else $error("ttt_fifo: count mismatch");
`endif

endmodule

// File: src/template_tag_tokenizer.sv
// Template tag tokenizer: one template byte per item, token descriptors out.
// Latency: with an empty queue, the first result of an item is offered in the cycle
// after it is accepted.
// Throughput: one item per cycle while ready is high; results leave a four-entry queue one per cycle
// while the receiver is ready, so an item with several results holds the output until all have left.
// Ready is high while the queue holds at most one result.
// Reset clears the scanner to text mode, line 1, offset 0, and empties the queue.
module template_tag_tokenizer
  import ttt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_input_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  token_kind_o,
  output logic [20:0] start_offset_o,
  output logic [20:0] token_length_o,
  output logic [19:0] line_number_o,
  output logic        last_of_run_o
);

  logic   accept;
  push_t  push;
  token_t head;

  assign accept = in_valid_i && in_ready_o;

  // Scanner: decides each item against the pending byte.
  ttt_lexer u_lexer (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .data_byte_i    (data_byte_i),
    .end_of_input_i (end_of_input_i),
    .push_o         (push)
  );

  // Result queue between the scanner and the output.
  ttt_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (out_ready_i),
    .room_o  (in_ready_o),
    .valid_o (out_valid_o),
    .head_o  (head)
  );

  assign token_kind_o   = head.kind;
  assign start_offset_o = head.start;
  assign token_length_o = head.len;
  assign line_number_o  = head.line;
  assign last_of_run_o  = head.last;

endmodule

// File: bench/tb_template_tag_tokenizer.sv
// Self-checking testbench for the template tag tokenizer.
// Drives documents byte by byte, predicts each token descriptor and checks every result item.
// Depends on ttt_pkg and template_tag_tokenizer.
module tb_template_tag_tokenizer;
  import ttt_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 100000;

  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_USCORE = 8'h5F;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;

  typedef enum logic [2:0] {
    SCAN_IDLE, SCAN_TEXT, SCAN_IDENT, SCAN_NUMBER, SCAN_STRING, SCAN_HELD
  } scan_e;

  logic        clk_i;
  logic        rst_ni         = 1'b0;
  logic        in_valid_i     = 1'b0;
  logic        in_ready_o;
  logic [7:0]  data_byte_i    = 8'h00;
  logic        end_of_input_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i    = 1'b0;
  logic [3:0]  token_kind_o;
  logic [20:0] start_offset_o;
  logic [20:0] token_length_o;
  logic [19:0] line_number_o;
  logic        last_of_run_o;

  // Scanner state of the predictor.
  logic              in_tag;
  scan_e             scan;
  logic [7:0]        cur_byte;
  logic              cur_valid;
  logic [POS_W-1:0]  cur_pos;
  logic [POS_W-1:0]  tok_start;
  logic [LINE_W-1:0] line_cnt;
  kind_e             held_kind;
  logic [POS_W-1:0]  held_start;

  token_t      item_tokens[$];
  token_t      expected_tokens[$];
  logic [7:0]  doc_bytes[$];
  int unsigned items_sent  = 0;
  int unsigned err_count   = 0;
  int unsigned cycle_count = 0;
  bit          steady      = 1'b0;

  template_tag_tokenizer dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .end_of_input_i (end_of_input_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .token_kind_o   (token_kind_o),
    .start_offset_o (start_offset_o),
    .token_length_o (token_length_o),
    .line_number_o  (line_number_o),
    .last_of_run_o  (last_of_run_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Character classes.
  function automatic bit is_letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit is_num(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_word(logic [7:0] c);
    return is_letter(c) || is_num(c) || c == CH_USCORE;
  endfunction

  function automatic bit is_blank(logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR;
  endfunction

  function automatic bit opens(logic [7:0] c);
    return c == CH_LBRACE || c == CH_PCT || c == CH_HASH;
  endfunction

  function automatic kind_e opener_of(logic [7:0] c);
    case (c)
      CH_LBRACE: return K_VAR_OPEN;
      CH_PCT:    return K_STMT_OPEN;
      default:   return K_CMT_OPEN;
    endcase
  endfunction

  // Offsets saturate at the document limit; differences never go negative.
  function automatic logic [POS_W-1:0] pos_inc(logic [POS_W-1:0] v);
    return (v < POS_CAP) ? v + 1'b1 : POS_CAP;
  endfunction

  function automatic logic [POS_W-1:0] span(logic [POS_W-1:0] a, logic [POS_W-1:0] b);
    return (a > b) ? a - b : '0;
  endfunction

  function automatic logic [7:0] pick(string s);
    return s[$urandom_range(0, s.len() - 1)];
  endfunction

  // Back to the start of a document: text mode, offset 0, line 1.
  task automatic clear_doc();
    in_tag     = 1'b0;
    scan       = SCAN_IDLE;
    cur_byte   = 8'h00;
    cur_valid  = 1'b0;
    cur_pos    = '0;
    tok_start  = '0;
    line_cnt   = LINE_W'(1);
    held_kind  = K_TEXT;
    held_start = '0;
  endtask

  // Records one token of the current item, taking the line count as it stands now.
  task automatic note_token(kind_e k, logic [POS_W-1:0] s, logic [POS_W-1:0] l);
    token_t t;
    if (item_tokens.size() < MAX_RESULTS) begin
      t.kind  = k;
      t.start = s;
      t.len   = l;
      t.line  = line_cnt;
      t.last  = 1'b0;
      item_tokens.push_back(t);
    end
  endtask

  // The lookahead byte becomes the current byte.
  task automatic advance(logic [7:0] b);
    if (cur_valid) cur_pos = pos_inc(cur_pos);
    cur_byte  = b;
    cur_valid = 1'b1;
    if (b == CH_LF && line_cnt < LINE_CAP) line_cnt = line_cnt + 1'b1;
  endtask

  // A delimiter is held back one item so that its line includes the next byte.
  task automatic hold_delimiter(kind_e k, logic tag, logic [7:0] b);
    held_kind  = k;
    held_start = cur_pos;
    in_tag     = tag;
    advance(b);
    scan = SCAN_HELD;
  endtask

  // Tag mode with no token open: decide on the current byte given the lookahead.
  task automatic tag_start(logic [7:0] c, logic [7:0] b);
    if (is_blank(c)) begin
      advance(b);
    end else if (b == CH_RBRACE && c == CH_RBRACE) begin
      hold_delimiter(K_VAR_CLOSE, 1'b0, b);
    end else if (b == CH_RBRACE && c == CH_PCT) begin
      hold_delimiter(K_STMT_CLOSE, 1'b0, b);
    end else if (b == CH_RBRACE && c == CH_HASH) begin
      hold_delimiter(K_CMT_CLOSE, 1'b0, b);
    end else if (c == CH_LBRACE && opens(b)) begin
      hold_delimiter(opener_of(b), 1'b1, b);
    end else if (is_letter(c) || c == CH_USCORE) begin
      tok_start = cur_pos;
      scan = SCAN_IDENT;
      advance(b);
    end else if (is_num(c)) begin
      tok_start = cur_pos;
      scan = SCAN_NUMBER;
      advance(b);
    end else if (c == CH_QUOTE) begin
      tok_start = pos_inc(cur_pos);
      scan = SCAN_STRING;
      advance(b);
    end else begin
      note_token(K_ILLEGAL, cur_pos, POS_W'(1));
      advance(b);
    end
  endtask

  // Tag mode with no token open and the document ending after the current byte.
  task automatic tag_start_final(logic [7:0] c, logic [POS_W-1:0] endp);
    if (is_blank(c)) begin
    end else if (is_letter(c) || c == CH_USCORE) begin
      note_token(K_IDENT, cur_pos, span(endp, cur_pos));
    end else if (is_num(c)) begin
      note_token(K_NUMBER, cur_pos, span(endp, cur_pos));
    end else if (c == CH_QUOTE) begin
      note_token(K_STRING, endp, '0);
    end else begin
      note_token(K_ILLEGAL, cur_pos, POS_W'(1));
    end
  endtask

  // One data byte arrives as the lookahead.
  task automatic take_byte(logic [7:0] b);
    logic [7:0]       c;
    logic [POS_W-1:0] len;
    bit               more;
    c = cur_byte;
    if (!cur_valid) begin
      advance(b);
    end else begin
      case (scan) inside
        SCAN_HELD: begin
          advance(b);
          note_token(held_kind, held_start, POS_W'(2));
          scan = SCAN_IDLE;
        end
        SCAN_IDENT, SCAN_NUMBER: begin
          more = (scan == SCAN_IDENT) ? is_word(c) : is_num(c);
          if (more) begin
            advance(b);
          end else begin
            note_token((scan == SCAN_IDENT) ? K_IDENT : K_NUMBER, tok_start,
                       span(cur_pos, tok_start));
            scan = SCAN_IDLE;
            tag_start(c, b);
          end
        end
        SCAN_STRING: begin
          if (c == CH_QUOTE) begin
            len = span(cur_pos, tok_start);
            advance(b);
            note_token(K_STRING, tok_start, len);
            scan = SCAN_IDLE;
          end else begin
            advance(b);
          end
        end
        SCAN_TEXT: begin
          if (c == CH_LBRACE && opens(b)) begin
            note_token(K_TEXT, tok_start, span(cur_pos, tok_start));
            scan = SCAN_IDLE;
            hold_delimiter(opener_of(b), 1'b1, b);
          end else begin
            advance(b);
          end
        end
        default: begin
          if (in_tag) begin
            tag_start(c, b);
          end else if (c == CH_LBRACE && opens(b)) begin
            hold_delimiter(opener_of(b), 1'b1, b);
          end else begin
            tok_start = cur_pos;
            scan = SCAN_TEXT;
            advance(b);
          end
        end
      endcase
    end
  endtask

  // End of document: flush whatever is open, then the end token.
  task automatic finish_doc();
    logic [7:0]       c;
    logic [POS_W-1:0] endp;
    kind_e            k;
    c = cur_byte;
    endp = cur_valid ? pos_inc(cur_pos) : '0;
    if (cur_valid) begin
      case (scan) inside
        SCAN_HELD: note_token(held_kind, held_start, POS_W'(2));
        SCAN_IDENT, SCAN_NUMBER: begin
          k = (scan == SCAN_IDENT) ? K_IDENT : K_NUMBER;
          if ((scan == SCAN_IDENT) ? is_word(c) : is_num(c)) begin
            note_token(k, tok_start, span(endp, tok_start));
          end else begin
            note_token(k, tok_start, span(cur_pos, tok_start));
            tag_start_final(c, endp);
          end
        end
        SCAN_STRING: note_token(K_STRING, tok_start,
                                span((c == CH_QUOTE) ? cur_pos : endp, tok_start));
        SCAN_TEXT: note_token(K_TEXT, tok_start, span(endp, tok_start));
        default: begin
          if (!in_tag) note_token(K_TEXT, cur_pos, span(endp, cur_pos));
          else tag_start_final(c, endp);
        end
      endcase
    end
    note_token(K_END, endp, '0);
    clear_doc();
  endtask

  // Works out the tokens of one accepted item and queues them, the last one marked.
  task automatic predict_tokens(logic [7:0] b, logic doc_end);
    token_t t;
    item_tokens.delete();
    if (doc_end) finish_doc();
    else take_byte(b);
    for (int i = 0; i < item_tokens.size(); i++) begin
      t = item_tokens[i];
      t.last = (i == item_tokens.size() - 1);
      expected_tokens.push_back(t);
    end
  endtask

  // Offers one item, with random idle cycles first unless running back to back.
  task automatic send_byte(logic [7:0] b, logic doc_end);
    while (!steady && $urandom_range(0, 99) < 16) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    data_byte_i    <= b;
    end_of_input_i <= doc_end;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    items_sent++;
    predict_tokens(b, doc_end);
  endtask

  // Sends the bytes in doc_bytes, then the end-of-input item with random data.
  task automatic send_doc();
    foreach (doc_bytes[i]) send_byte(doc_bytes[i], 1'b0);
    send_byte(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // Builds a document of text runs and tags with random content, plus noise
  // and broken delimiters now and then.
  task automatic build_random_doc();
    logic [7:0] opener;
    doc_bytes.delete();
    repeat ($urandom_range(1, 6)) begin
      case ($urandom_range(0, 9))
        0, 1, 2: repeat ($urandom_range(1, 6)) doc_bytes.push_back(pick("ab Z9_\n\t{}%#\"x"));
        3, 4, 5, 6: begin
          opener = pick("{%#");
          doc_bytes.push_back(CH_LBRACE);
          doc_bytes.push_back(opener);
          repeat ($urandom_range(0, 4)) begin
            if ($urandom_range(0, 1) == 0) doc_bytes.push_back(CH_SPACE);
            case ($urandom_range(0, 5))
              0: doc_bytes.push_back(pick(" \t\n\r"));
              1: begin
                doc_bytes.push_back(pick("abcxyzABZ_"));
                repeat ($urandom_range(0, 4)) doc_bytes.push_back(pick("az09_Q"));
              end
              2: repeat ($urandom_range(1, 4)) doc_bytes.push_back(pick("0123456789"));
              3: begin
                doc_bytes.push_back(CH_QUOTE);
                repeat ($urandom_range(0, 3)) doc_bytes.push_back(pick("ab {}%\n"));
                if ($urandom_range(0, 4) != 0) doc_bytes.push_back(CH_QUOTE);
              end
              4: begin
                if ($urandom_range(0, 1) == 0) doc_bytes.push_back(pick("+-=.|(~"));
                else doc_bytes.push_back(8'($urandom_range(128, 255)));
              end
              default: doc_bytes.push_back(pick("{}%#"));
            endcase
          end
          // Mostly the matching closer, sometimes a broken one.
          if ($urandom_range(0, 9) != 0) begin
            doc_bytes.push_back((opener == CH_LBRACE) ? CH_RBRACE : opener);
            doc_bytes.push_back(CH_RBRACE);
          end else begin
            doc_bytes.push_back(pick("}%#"));
          end
        end
        7: repeat ($urandom_range(1, 4)) doc_bytes.push_back(8'($urandom_range(0, 255)));
        8: begin
          // Extreme byte values, the zero byte among them.
          case ($urandom_range(0, 3))
            0:       doc_bytes.push_back(8'h00);
            1:       doc_bytes.push_back(8'h7F);
            2:       doc_bytes.push_back(8'h80);
            default: doc_bytes.push_back(8'hFF);
          endcase
        end
        default: begin
          doc_bytes.push_back(CH_QUOTE);
          repeat ($urandom_range(0, 3)) doc_bytes.push_back(pick("ab1 "));
        end
      endcase
    end
  endtask

  // Every token kind, zero and all-ones bytes, delimiter timing, a quote as the
  // last byte, and a second document straight after an end token.
  task automatic test_directed_docs();
    doc_bytes = '{8'h00, CH_LBRACE, CH_PCT, 8'hFF, CH_QUOTE, "q", CH_QUOTE, "7",
                  CH_PCT, CH_RBRACE, CH_LBRACE, CH_HASH, CH_USCORE, CH_HASH, CH_RBRACE};
    send_doc();
    doc_bytes = '{CH_LBRACE, CH_LBRACE, CH_RBRACE, CH_RBRACE, CH_LBRACE, CH_LBRACE, CH_QUOTE};
    send_doc();
  endtask

  // Random documents with no idling on either side.
  task automatic test_back_to_back_docs();
    steady = 1'b1;
    while (items_sent < 110) begin
      build_random_doc();
      send_doc();
    end
    steady = 1'b0;
  endtask

  // Random documents with random gaps on both sides.
  task automatic test_random_docs();
    while (items_sent < 370) begin
      build_random_doc();
      send_doc();
    end
  endtask

  // The receiver stalls at random except during the back-to-back stretch.
  always @(posedge clk_i) begin
    out_ready_i <= steady || ($urandom_range(0, 99) >= 16);
  end

  // Compare each accepted result with the oldest expected token.
  always @(posedge clk_i) begin : check_tokens
    token_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_tokens.size() == 0) begin
        $error("unexpected token: kind %0d offset %0d", token_kind_o, start_offset_o);
        err_count++;
      end else begin
        want = expected_tokens.pop_front();
        if (token_kind_o !== want.kind) begin
          $error("token_kind: expected %0d, got %0d", want.kind, token_kind_o);
          err_count++;
        end
        if (start_offset_o !== want.start) begin
          $error("start_offset: expected %0d, got %0d", want.start, start_offset_o);
          err_count++;
        end
        if (token_length_o !== want.len) begin
          $error("token_length: expected %0d, got %0d", want.len, token_length_o);
          err_count++;
        end
        if (line_number_o !== want.line) begin
          $error("line_number: expected %0d, got %0d", want.line, line_number_o);
          err_count++;
        end
        if (last_of_run_o !== want.last) begin
          $error("last_of_run: expected %0d, got %0d", want.last, last_of_run_o);
          err_count++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_template_tag_tokenizer failed");
      $finish;
    end
  end

  // Reset, the tests in turn, then drain and report.
  initial begin
    clear_doc();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_docs();
    test_back_to_back_docs();
    test_random_docs();
    in_valid_i <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (err_count == 0) begin
      $display("tb_template_tag_tokenizer passed");
    end else begin
      $display("tb_template_tag_tokenizer failed");
    end
    $finish;
  end

endmodule

// File: template_tag_tokenizer.f
src/ttt_pkg.sv
src/ttt_lexer.sv
src/ttt_fifo.sv
src/template_tag_tokenizer.sv
bench/tb_template_tag_tokenizer.sv
